// ===== hw/rtl/bad_pkg.sv =====
// shared types and constants of the box average downsampler
package bad_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxWindow = 64;
  localparam int ColW = $clog2(MaxWidth);
  localparam int OffW = $clog2(MaxWindow);
  localparam int CntW = $clog2(MaxWidth) + 1;
  localparam int SumW = 20;

  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH  = 2'd1;

  typedef struct packed {
    logic [7:0]      pixel;
    logic [ColW-1:0] bin;
    logic            emit;
    logic            eol;
    logic [CntW-1:0] cnt;
  } work_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_PUT
  } back_state_t;

endpackage

// ===== hw/rtl/box_average_downsample_unit.sv =====
// top level of the box average downsampler
//
// Pixels enter in raster order through a queue-like port: an item is taken
// when push is high and full is low. Results leave the same way: while empty
// is low, average and end_of_row show the oldest result, taken when pop is high.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// window edge (index 0) and the line width (index 1); each write to one of them
// restarts the image. cfg_ready is always high.
// After reset and after every write to these registers the bin sum memory is
// swept clear, one entry a cycle; full stays high meanwhile.
// Each item passes through the back end's idle and accumulate states for the
// read-modify-write of its bin sum through the single memory port; an item
// that closes a window then steps through the bit-serial divider and a put
// state that enters the result into the result queue.
// A two-entry queue buffers items between front and back, and a two-entry
// result queue holds results; when the receiver stalls, both fill and full
// rises.
module box_average_downsample_unit import bad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  average,
  output logic        end_of_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  work_t      f_work;
  work_t      q_work;
  back_stat_t stat;
  logic       restart;
  logic       accept;
  logic       q_full;
  logic       q_empty;
  logic       q_rd;

  assign cfg_ready = 1'b1;
  assign full   = q_full || stat.clearing;
  assign accept = push && !full;

  bad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .accept    (accept),
    .pixel     (pixel),
    .work      (f_work)
  );

  bad_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (f_work),
    .rd      (q_rd),
    .rd_data (q_work),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bad_back u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .work       (q_work),
    .q_empty    (q_empty),
    .q_rd       (q_rd),
    .stat       (stat),
    .pop        (pop),
    .empty      (empty),
    .average    (average),
    .end_of_row (end_of_row)
  );

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> full)
    else $error("item accepted during clear sweep");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> stat.clearing)
    else $error("register write did not start clear sweep");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("back end read an empty queue");

endmodule

// ===== hw/rtl/bad_front.sv =====
// front end: config registers, raster position tracking and item classification
module bad_front import bad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_data,
  output logic                  restart,
  input  logic                  accept,
  input  logic [7:0]            pixel,
  output work_t                 work
);

  logic [6:0]      window_size;
  logic [12:0]     line_width;
  logic [ColW-1:0] column_position;
  logic [OffW-1:0] offset_in_bin;
  logic [ColW-1:0] bin_index;
  logic [OffW-1:0] row_in_window;
  logic [6:0]      n;
  logic [12:0]     w;
  logic            last_in_line;
  logic            last_in_bin;
  logic [13:0]     prod;

  always_comb begin
    if (window_size == 7'd0) n = 7'd1;
    else if (window_size > 7'(MaxWindow)) n = 7'(MaxWindow);
    else n = window_size;
    if (line_width == 13'd0) w = 13'd1;
    else if (line_width > 13'(MaxWidth)) w = 13'(MaxWidth);
    else w = line_width;
  end

  assign restart = cfg_wr && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_LINE_WIDTH);
  assign last_in_line = {1'b0, column_position} >= (w - 13'd1);
  assign last_in_bin  = ({1'b0, offset_in_bin} >= (n - 7'd1)) || last_in_line;
  assign prod = 14'({1'b0, offset_in_bin} + 7'd1) * 14'(n);

  always_comb begin
    work.pixel = pixel;
    work.bin   = bin_index;
    work.emit  = last_in_bin && ({1'b0, row_in_window} >= (n - 7'd1));
    work.eol   = last_in_line;
    work.cnt   = prod[CntW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size     <= 7'd1;
      line_width      <= 13'(MaxWidth);
      column_position <= '0;
      offset_in_bin   <= '0;
      bin_index       <= '0;
      row_in_window   <= '0;
    end else if (restart) begin
      if (cfg_index == REG_WINDOW_SIZE) window_size <= cfg_data[6:0];
      else line_width <= cfg_data;
      column_position <= '0;
      offset_in_bin   <= '0;
      bin_index       <= '0;
      row_in_window   <= '0;
    end else if (accept) begin
      if (last_in_line) begin
        column_position <= '0;
        offset_in_bin   <= '0;
        bin_index       <= '0;
        if ({1'b0, row_in_window} + 7'd1 >= n) row_in_window <= '0;
        else row_in_window <= row_in_window + 1'b1;
      end else if (last_in_bin) begin
        column_position <= column_position + 1'b1;
        offset_in_bin   <= '0;
        bin_index       <= bin_index + 1'b1;
      end else begin
        column_position <= column_position + 1'b1;
        offset_in_bin   <= offset_in_bin + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bad_queue.sv =====
// two-entry queue of classified items between front and back
module bad_queue import bad_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wr_data,
  input  logic  rd,
  output work_t rd_data,
  output logic  q_full,
  output logic  q_empty
);

  work_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign q_full  = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign rd_data = ent[rp];

  always_ff @(posedge clk) begin
    if (wr) ent[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== hw/rtl/bad_back.sv =====
// back end: bin sum memory, serial divider and result queue
module bad_back import bad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  work_t      work,
  input  logic       q_empty,
  output logic       q_rd,
  output back_stat_t stat,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] average,
  output logic       end_of_row
);

  back_state_t state;
  back_state_t state_next;

  logic [SumW-1:0] mem [MaxWidth];
  logic [SumW-1:0] rd_q;
  logic [ColW-1:0] clr_addr;
  work_t           cur;
  logic [21:0]     rem;
  logic [CntW:0]   den;
  logic [8:0]      quo;
  logic [3:0]      step;
  logic [SumW-1:0] sum;
  logic [22:0]     trial;
  logic            fits;

  logic [7:0] o_avg [2];
  logic       o_eol [2];
  logic       owp;
  logic       orp;
  logic [1:0] ocount;
  logic       o_full;
  logic       o_push;
  logic       o_pop;

  assign sum   = rd_q + SumW'(cur.pixel);
  assign trial = 23'({9'd0, den} << step);
  assign fits  = {1'b0, rem} >= trial;
  assign o_full = ocount == 2'd2;
  assign empty  = ocount == 2'd0;
  assign o_pop  = pop && !empty;
  assign average    = o_avg[orp];
  assign end_of_row = o_eol[orp];
  assign stat.clearing = state == ST_CLEAR;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ColW'(MaxWidth - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_next = ST_ACC;
      ST_ACC:   state_next = cur.emit ? ST_DIV : ST_IDLE;
      ST_DIV:   if (step == 4'd0) state_next = ST_PUT;
      ST_PUT:   if (!o_full) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
    if (restart) state_next = ST_CLEAR;
  end

  always_comb begin
    q_rd   = (state == ST_IDLE) && !q_empty;
    o_push = (state == ST_PUT) && !o_full;
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) mem[clr_addr] <= '0;
    else if (state == ST_ACC) mem[cur.bin] <= cur.emit ? '0 : sum;
    if (q_rd) rd_q <= mem[work.bin];
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= work;
    case (state)
      ST_ACC: begin
        rem  <= 22'({sum, 1'b0}) + 22'(cur.cnt);
        den  <= {cur.cnt, 1'b0};
        quo  <= '0;
        step <= 4'd8;
      end
      ST_DIV: begin
        if (fits) begin
          rem <= 22'({1'b0, rem} - trial);
          quo[step] <= 1'b1;
        end
        step <= step - 4'd1;
      end
      default: ;
    endcase
    if (o_push) begin
      o_avg[owp] <= (quo > 9'd255) ? 8'd255 : quo[7:0];
      o_eol[owp] <= cur.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      owp      <= 1'b0;
      orp      <= 1'b0;
      ocount   <= 2'd0;
    end else begin
      state <= state_next;
      if (restart) clr_addr <= '0;
      else if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (o_push) owp <= ~owp;
      if (o_pop) orp <= ~orp;
      ocount <= ocount + 2'(o_push) - 2'(o_pop);
    end
  end

endmodule
